[rtl/gradient_non_max_suppression_core_assert.svh]
// Assertion macro used by the checker module of this block.
`ifndef GRADIENT_NON_MAX_SUPPRESSION_CORE_ASSERT_SVH
`define GRADIENT_NON_MAX_SUPPRESSION_CORE_ASSERT_SVH

// Clocked property check that reports through $error; checks are off during reset.
`define GNMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

[rtl/gnms_pkg.sv]
package gnms_pkg;

    // Field widths of the gradient and result items.
    localparam int GRAD_W  = 11;
    localparam int MAG_W   = 15;
    localparam int DIR_W   = 2;
    localparam int CLASS_W = 2;
    localparam int ROW_W   = 13;
    localparam int IMGW_W  = 12;
    localparam int THR_W   = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Square root datapath: radicand is (gx^2 + gy^2) * 256.
    localparam int SUM_W  = 22;
    localparam int RAD_W  = 30;
    localparam int REM_W  = 18;
    localparam int ITER_W = 4;
    localparam int ROOT_STEPS = RAD_W / 2;

    // Tangent of 22.5 degrees scaled by 256.
    localparam int TAN_LO = 106;

    // Line store word: older magnitude, previous direction, previous magnitude.
    localparam int LINE_W = MAG_W + DIR_W + MAG_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 3'd3;

    // Gradient directions.
    localparam logic [DIR_W-1:0] DIR_HORZ = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DIAG_POS = 2'd1;
    localparam logic [DIR_W-1:0] DIR_VERT = 2'd2;
    localparam logic [DIR_W-1:0] DIR_DIAG_NEG = 2'd3;

    // Edge classes.
    localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_WEAK   = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_STRONG = 2'd2;

    // Item sequencer.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_READ,
        S_EMIT
    } t_state;

endpackage

[rtl/gnms_ram.sv]
module gnms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds when not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/gradient_non_max_suppression_core.sv]
// One item at a time: the input stalls until the item is done. Each item passes
// through the bit-serial square root (15 iterations) followed by the line store read
// and the write back; a stalled output holds the write back.
// Reset (synchronous, active low) clears counters, window and output valid and
// restores default registers; the line store is not cleared.
module gradient_non_max_suppression_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [gnms_pkg::GRAD_W-1:0] i_grad_x,
    input  logic signed [gnms_pkg::GRAD_W-1:0] i_grad_y,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [gnms_pkg::MAG_W-1:0]         o_kept_magnitude,
    output logic [gnms_pkg::CLASS_W-1:0]       o_edge_class,
    output logic                               o_frame_end,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gnms_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gnms_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > gnms_pkg::IMGW_W) ? CW + 1 : gnms_pkg::IMGW_W;
    localparam int MW = gnms_pkg::MAG_W;
    localparam int GW = gnms_pkg::GRAD_W;

    gnms_pkg::t_state r_state, n_state;

    logic [gnms_pkg::IMGW_W-1:0] r_img_w;
    logic [gnms_pkg::ROW_W-1:0]  r_img_h;
    logic [gnms_pkg::THR_W-1:0]  r_low_thr;
    logic [gnms_pkg::THR_W-1:0]  r_high_thr;

    logic [CW-1:0]                r_col;
    logic [gnms_pkg::ROW_W-1:0]   r_row;

    logic [GW-1:0]                r_ax, r_ay;
    logic                         r_neg_x, r_neg_y;
    logic [gnms_pkg::DIR_W-1:0]   r_dir;
    logic [gnms_pkg::RAD_W-1:0]   r_rad;
    logic [gnms_pkg::REM_W-1:0]   r_rem;
    logic [MW-1:0]                r_root;
    logic [gnms_pkg::ITER_W-1:0]  r_iter;

    logic [MW-1:0]                r_win_mag [3][3];
    logic [gnms_pkg::DIR_W-1:0]   r_win_dir [3];

    logic                         r_out_valid;
    logic [MW-1:0]                r_out_mag;
    logic [gnms_pkg::CLASS_W-1:0] r_out_class;
    logic                         r_out_end;

    logic accept, do_load, do_step, do_read, do_emit, out_free;

    // Configuration writes, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w    <= gnms_pkg::IMGW_W'(640);
            r_img_h    <= gnms_pkg::ROW_W'(480);
            r_low_thr  <= gnms_pkg::THR_W'(20);
            r_high_thr <= gnms_pkg::THR_W'(70);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gnms_pkg::REG_WIDTH:  r_img_w    <= i_cfg_data[gnms_pkg::IMGW_W-1:0];
                gnms_pkg::REG_HEIGHT: r_img_h    <= i_cfg_data[gnms_pkg::ROW_W-1:0];
                gnms_pkg::REG_LOW:    r_low_thr  <= i_cfg_data[gnms_pkg::THR_W-1:0];
                gnms_pkg::REG_HIGH:   r_high_thr <= i_cfg_data[gnms_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size after clamping.
    logic [EW-1:0]              img_w_ext, w_eff;
    logic [gnms_pkg::ROW_W-1:0] h_eff;

    always_comb begin
        img_w_ext = EW'(r_img_w);
        if (img_w_ext < EW'(3)) begin
            w_eff = EW'(3);
        end else if (img_w_ext > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = img_w_ext;
        end
        h_eff = (r_img_h < gnms_pkg::ROW_W'(3)) ? gnms_pkg::ROW_W'(3) : r_img_h;
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = i_in_valid && (r_state == gnms_pkg::S_IDLE);

    // Sequencer: next state and datapath strobes.
    always_comb begin
        n_state = r_state;
        do_load = 1'b0;
        do_step = 1'b0;
        do_read = 1'b0;
        do_emit = 1'b0;
        unique case (r_state)
            gnms_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = gnms_pkg::S_SQUARE;
                end
            end
            gnms_pkg::S_SQUARE: begin
                do_load = 1'b1;
                n_state = gnms_pkg::S_ROOT;
            end
            gnms_pkg::S_ROOT: begin
                do_step = 1'b1;
                if (r_iter == gnms_pkg::ITER_W'(gnms_pkg::ROOT_STEPS - 1)) begin
                    n_state = gnms_pkg::S_READ;
                end
            end
            gnms_pkg::S_READ: begin
                do_read = 1'b1;
                n_state = gnms_pkg::S_EMIT;
            end
            gnms_pkg::S_EMIT: begin
                if (out_free) begin
                    do_emit = 1'b1;
                    n_state = gnms_pkg::S_IDLE;
                end
            end
            default: n_state = gnms_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gnms_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != gnms_pkg::S_IDLE);

    // Absolute values and signs captured on the input transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax    <= i_grad_x[GW-1] ? (GW'(0) - GW'(i_grad_x)) : GW'(i_grad_x);
            r_ay    <= i_grad_y[GW-1] ? (GW'(0) - GW'(i_grad_y)) : GW'(i_grad_y);
            r_neg_x <= i_grad_x[GW-1];
            r_neg_y <= i_grad_y[GW-1];
        end
    end

    // Squares, radicand and direction sector.
    logic [2*GW-1:0]          sq_x, sq_y;
    logic [gnms_pkg::SUM_W-1:0] sq_sum;
    logic [GW+8-1:0]          ay_hi, ax_hi, ay_lo, ax_lo;
    logic [gnms_pkg::DIR_W-1:0] dir_c;

    always_comb begin
        sq_x   = (2*GW)'(r_ax) * (2*GW)'(r_ax);
        sq_y   = (2*GW)'(r_ay) * (2*GW)'(r_ay);
        sq_sum = gnms_pkg::SUM_W'(sq_x) + gnms_pkg::SUM_W'(sq_y);
        ay_hi  = {r_ay, 8'd0};
        ax_hi  = {r_ax, 8'd0};
        ax_lo  = (GW+8)'(r_ax) * (GW+8)'(gnms_pkg::TAN_LO);
        ay_lo  = (GW+8)'(r_ay) * (GW+8)'(gnms_pkg::TAN_LO);
        if (ay_hi <= ax_lo) begin
            dir_c = gnms_pkg::DIR_HORZ;
        end else if (ay_lo > ax_hi) begin
            dir_c = gnms_pkg::DIR_VERT;
        end else if (r_neg_x == r_neg_y) begin
            dir_c = gnms_pkg::DIR_DIAG_POS;
        end else begin
            dir_c = gnms_pkg::DIR_DIAG_NEG;
        end
    end

    // One result bit of the square root per cycle.
    logic [gnms_pkg::REM_W-1:0] rem_sh, trial;

    always_comb begin
        rem_sh = {r_rem[gnms_pkg::REM_W-3:0], r_rad[gnms_pkg::RAD_W-1 -: 2]};
        trial  = gnms_pkg::REM_W'({r_root, 2'b01});
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_rad  <= {sq_sum, 8'd0};
            r_rem  <= '0;
            r_root <= '0;
            r_iter <= '0;
            r_dir  <= dir_c;
        end else if (do_step) begin
            r_rad  <= {r_rad[gnms_pkg::RAD_W-3:0], 2'b00};
            r_iter <= r_iter + gnms_pkg::ITER_W'(1);
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[MW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[MW-2:0], 1'b0};
            end
        end
    end

    // Line store: read at the column in S_READ, write back in the emit cycle.
    logic [gnms_pkg::LINE_W-1:0] line_rd, line_wr;
    logic [MW-1:0]               up_mag, old_mag;
    logic [gnms_pkg::DIR_W-1:0]  up_dir;

    assign up_mag  = line_rd[MW-1:0];
    assign up_dir  = line_rd[MW +: gnms_pkg::DIR_W];
    assign old_mag = line_rd[gnms_pkg::LINE_W-1 -: MW];
    assign line_wr = {up_mag, r_dir, r_root};

    gnms_ram #(
        .WIDTH (gnms_pkg::LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (do_emit),
        .i_waddr (r_col),
        .i_wdata (line_wr),
        .i_re    (do_read),
        .i_raddr (r_col),
        .o_rdata (line_rd)
    );

    // Window shifted by one column, and the suppression decision on its centre.
    logic [MW-1:0]              n_win_mag [3][3];
    logic [gnms_pkg::DIR_W-1:0] n_win_dir [3];
    logic [MW-1:0]              nb_a, nb_b, kept;
    logic [gnms_pkg::CLASS_W-1:0] cls;
    logic [EW-1:0]              col_ext;
    logic                       has_result, last_pix;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win_mag[i][0] = r_win_mag[i][1];
            n_win_mag[i][1] = r_win_mag[i][2];
        end
        n_win_mag[0][2] = old_mag;
        n_win_mag[1][2] = up_mag;
        n_win_mag[2][2] = r_root;
        n_win_dir[0] = r_win_dir[1];
        n_win_dir[1] = r_win_dir[2];
        n_win_dir[2] = up_dir;

        unique case (n_win_dir[1])
            gnms_pkg::DIR_HORZ: begin
                nb_a = n_win_mag[1][0];
                nb_b = n_win_mag[1][2];
            end
            gnms_pkg::DIR_DIAG_POS: begin
                nb_a = n_win_mag[0][2];
                nb_b = n_win_mag[2][0];
            end
            gnms_pkg::DIR_VERT: begin
                nb_a = n_win_mag[0][1];
                nb_b = n_win_mag[2][1];
            end
            default: begin
                nb_a = n_win_mag[0][0];
                nb_b = n_win_mag[2][2];
            end
        endcase

        kept = (n_win_mag[1][1] > nb_a && n_win_mag[1][1] > nb_b) ? n_win_mag[1][1] : '0;
        cls  = gnms_pkg::CLASS_NONE;
        if (kept != '0) begin
            if (kept[MW-1:4] >= r_high_thr) begin
                cls = gnms_pkg::CLASS_STRONG;
            end else if (kept[MW-1:4] > r_low_thr) begin
                cls = gnms_pkg::CLASS_WEAK;
            end
        end

        col_ext    = EW'(r_col);
        has_result = (r_row >= gnms_pkg::ROW_W'(2)) && (col_ext >= EW'(2))
                     && (r_row < h_eff) && (col_ext < w_eff);
        last_pix   = (r_row == h_eff - gnms_pkg::ROW_W'(1))
                     && (col_ext == w_eff - EW'(1));
    end

    // Window, counters and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win_mag[i][j] <= '0;
                end
                r_win_dir[i] <= '0;
            end
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (do_emit) begin
                r_win_mag <= n_win_mag;
                r_win_dir <= n_win_dir;
                if (has_result) begin
                    r_out_valid <= 1'b1;
                end
                if (col_ext + EW'(1) >= w_eff) begin
                    r_col <= '0;
                    r_row <= ((gnms_pkg::ROW_W+1)'(r_row) + 1'b1 >= (gnms_pkg::ROW_W+1)'(h_eff))
                             ? '0 : r_row + gnms_pkg::ROW_W'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                    if (r_row >= h_eff) begin
                        r_row <= '0;
                    end
                end
            end
        end
    end

    // Result payload, loaded only when a result is produced.
    always_ff @(posedge i_clk) begin
        if (do_emit && has_result) begin
            r_out_mag   <= kept;
            r_out_class <= cls;
            r_out_end   <= last_pix;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kept_magnitude = r_out_mag;
    assign o_edge_class     = r_out_class;
    assign o_frame_end      = r_out_end;

endmodule

[rtl/gnms_checker.sv]
`include "gradient_non_max_suppression_core_assert.svh"

module gnms_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic signed [gnms_pkg::GRAD_W-1:0] i_grad_x,
    input logic signed [gnms_pkg::GRAD_W-1:0] i_grad_y,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [gnms_pkg::MAG_W-1:0]         o_kept_magnitude,
    input logic [gnms_pkg::CLASS_W-1:0]       o_edge_class,
    input logic                               o_frame_end,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [gnms_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [gnms_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Handshake events and the whole result payload.
    logic in_xfer, out_held, out_empty;
    logic [gnms_pkg::MAG_W+gnms_pkg::CLASS_W:0] out_word;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign out_held  = o_out_valid && i_out_stall;
    assign out_empty = o_out_valid && (o_kept_magnitude == '0);
    assign out_word  = {o_kept_magnitude, o_edge_class, o_frame_end};

    // A stalled result stays offered with the same payload.
    `GNMS_ASSERT(a_out_hold, out_held |=> o_out_valid && $stable(out_word), "stalled result changed")

    // A suppressed pixel never carries an edge class.
    `GNMS_ASSERT(a_zero_none, out_empty |-> o_edge_class == gnms_pkg::CLASS_NONE, "class on zero")

    // One item at a time: the input is busy right after a transfer.
    `GNMS_ASSERT(a_busy_after_in, in_xfer |=> o_in_stall, "input not busy after transfer")

    // A result never appears in the cycle right after an input transfer.
    `GNMS_ASSERT(a_no_early_out, in_xfer && !o_out_valid |=> !o_out_valid, "result too early")

endmodule

bind gradient_non_max_suppression_core gnms_checker u_gnms_checker (.*);

[bench/gradient_non_max_suppression_core_test.sv]
module gradient_non_max_suppression_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH = 2048;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_HOLD = 400;

    // Gradient modes for random frames.
    localparam int MODE_FULL  = 0;
    localparam int MODE_TIES  = 1;
    localparam int MODE_EDGES = 2;

    typedef struct packed {
        logic signed [gnms_pkg::GRAD_W-1:0] gx;
        logic signed [gnms_pkg::GRAD_W-1:0] gy;
    } t_gradient;

    typedef struct packed {
        logic [gnms_pkg::MAG_W-1:0]   mag;
        logic [gnms_pkg::CLASS_W-1:0] cls;
        logic                         fend;
    } t_edge_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic signed [gnms_pkg::GRAD_W-1:0] grad_x = '0;
    logic signed [gnms_pkg::GRAD_W-1:0] grad_y = '0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [gnms_pkg::CFG_IDX_W-1:0] cfg_index = gnms_pkg::REG_WIDTH;
    logic [gnms_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic o_in_stall, o_out_valid, o_cfg_ready, o_frame_end;
    logic [gnms_pkg::MAG_W-1:0] o_kept_magnitude;
    logic [gnms_pkg::CLASS_W-1:0] o_edge_class;

    gradient_non_max_suppression_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_grad_x         (grad_x),
        .i_grad_y         (grad_y),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_kept_magnitude (o_kept_magnitude),
        .o_edge_class     (o_edge_class),
        .o_frame_end      (o_frame_end),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Predictor state: registers, counters, line stores and the 3x3 window.
    bit [11:0] width_reg = 12'd640;
    bit [12:0] height_reg = 13'd480;
    bit [10:0] low_reg = 11'd20;
    bit [10:0] high_reg = 11'd70;
    int col_cnt = 0;
    int row_cnt = 0;
    bit [gnms_pkg::MAG_W-1:0] line_mag [LINE_DEPTH];
    bit [gnms_pkg::DIR_W-1:0] line_dir [LINE_DEPTH];
    bit [gnms_pkg::MAG_W-1:0] line_old [LINE_DEPTH];
    bit [gnms_pkg::MAG_W-1:0] win_mag [3][3];
    bit [gnms_pkg::DIR_W-1:0] win_dir [3];

    t_gradient pending_gradients[$];
    t_edge_result expected_edges[$];

    int errors = 0;
    int grads_taken = 0;
    int edges_seen = 0;
    int kept_seen = 0;
    int settings_used = 0;
    bit burst = 1'b0;
    bit hold_req = 1'b0;

    // Integer square root, one result bit per step from the top.
    function automatic bit [gnms_pkg::MAG_W-1:0] root_q4(input longint unsigned sum_sq);
        longint unsigned rad;
        bit [gnms_pkg::MAG_W-1:0] root;
        bit [gnms_pkg::MAG_W-1:0] trial;
        rad = sum_sq * 256;
        root = '0;
        for (int b = gnms_pkg::MAG_W - 1; b >= 0; b--) begin
            trial = root | (gnms_pkg::MAG_W'(1) << b);
            if (longint'(trial) * longint'(trial) <= rad)
                root = trial;
        end
        return root;
    endfunction

    // Advance the model by one gradient pixel and queue the result it causes.
    function automatic void predict_pixel(input t_gradient g);
        int w, h, ax, ay, c, r;
        bit [gnms_pkg::MAG_W-1:0] mag, up_mag, old_mag, centre, na, nb, kept;
        bit [gnms_pkg::DIR_W-1:0] dir, up_dir;
        bit [gnms_pkg::CLASS_W-1:0] cls;
        t_edge_result e;
        w = width_reg;
        h = height_reg;
        if (w < 3) w = 3;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (h < 3) h = 3;
        c = col_cnt;
        r = row_cnt;
        ax = (g.gx < 0) ? -int'(g.gx) : int'(g.gx);
        ay = (g.gy < 0) ? -int'(g.gy) : int'(g.gy);
        mag = root_q4(longint'(ax * ax + ay * ay));
        if (ay * 256 <= ax * gnms_pkg::TAN_LO)
            dir = gnms_pkg::DIR_HORZ;
        else if (ay * gnms_pkg::TAN_LO > ax * 256)
            dir = gnms_pkg::DIR_VERT;
        else
            dir = ((g.gx < 0) == (g.gy < 0)) ? gnms_pkg::DIR_DIAG_POS : gnms_pkg::DIR_DIAG_NEG;

        up_mag = '0;
        up_dir = gnms_pkg::DIR_HORZ;
        old_mag = '0;
        if (c < LINE_DEPTH) begin
            up_mag = line_mag[c];
            up_dir = line_dir[c];
            old_mag = line_old[c];
            line_old[c] = up_mag;
            line_mag[c] = mag;
            line_dir[c] = dir;
        end

        for (int i = 0; i < 3; i++) begin
            win_mag[i][0] = win_mag[i][1];
            win_mag[i][1] = win_mag[i][2];
        end
        win_mag[0][2] = old_mag;
        win_mag[1][2] = up_mag;
        win_mag[2][2] = mag;
        win_dir[0] = win_dir[1];
        win_dir[1] = win_dir[2];
        win_dir[2] = up_dir;

        // Interior centres are judged against their two neighbours along the gradient.
        if (r >= 2 && c >= 2 && r < h && c < w) begin
            centre = win_mag[1][1];
            case (win_dir[1])
                gnms_pkg::DIR_HORZ: begin
                    na = win_mag[1][0];
                    nb = win_mag[1][2];
                end
                gnms_pkg::DIR_DIAG_POS: begin
                    na = win_mag[0][2];
                    nb = win_mag[2][0];
                end
                gnms_pkg::DIR_VERT: begin
                    na = win_mag[0][1];
                    nb = win_mag[2][1];
                end
                default: begin
                    na = win_mag[0][0];
                    nb = win_mag[2][2];
                end
            endcase
            kept = (centre > na && centre > nb) ? centre : '0;
            cls = gnms_pkg::CLASS_NONE;
            if (kept != 0) begin
                if ((kept >> 4) >= high_reg)
                    cls = gnms_pkg::CLASS_STRONG;
                else if ((kept >> 4) > low_reg)
                    cls = gnms_pkg::CLASS_WEAK;
            end
            e.mag = kept;
            e.cls = cls;
            e.fend = (r == h - 1 && c == w - 1);
            expected_edges.push_back(e);
        end

        if (c + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
            if (r >= h) row_cnt = 0;
        end
    endfunction

    // Sender: presents queued gradients with a random gap after each one unless in burst mode.
    bit in_taken = 1'b0;
    int in_gap = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !o_in_stall) begin
            predict_pixel('{gx: grad_x, gy: grad_y});
            in_taken = 1'b1;
            grads_taken++;
        end
    end

    always @(negedge i_clk) begin
        t_gradient g;
        bit next_valid;
        if (i_rst_n && (!in_valid || in_taken)) begin
            in_taken = 1'b0;
            next_valid = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_gradients.size() > 0) begin
                g = pending_gradients.pop_front();
                grad_x <= g.gx;
                grad_y <= g.gy;
                next_valid = 1'b1;
                in_gap = burst ? 0 : $urandom_range(0, 10);
            end
            in_valid <= next_valid;
        end
    end

    // Receiver: stalls a random number of cycles after each result transfer.
    bit out_taken = 1'b0;
    int out_wait = 0;
    int hold_left = 0;

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
        end
        if (out_taken) begin
            out_taken = 1'b0;
            out_wait = burst ? 0 : $urandom_range(0, 10);
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (out_wait > 0) begin
            out_wait--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Result check against the oldest expectation.
    always @(posedge i_clk) begin
        t_edge_result e;
        if (i_rst_n && o_out_valid && !out_stall) begin
            out_taken = 1'b1;
            edges_seen++;
            if (expected_edges.size() == 0) begin
                $error("result transfer with no expectation: mag %0d class %0d end %0d",
                       o_kept_magnitude, o_edge_class, o_frame_end);
                errors++;
            end else begin
                e = expected_edges.pop_front();
                if (e.mag != 0) kept_seen++;
                if (o_kept_magnitude !== e.mag) begin
                    $error("kept_magnitude: expected %0d, got %0d", e.mag, o_kept_magnitude);
                    errors++;
                end
                if (o_edge_class !== e.cls) begin
                    $error("edge_class: expected %0d, got %0d", e.cls, o_edge_class);
                    errors++;
                end
                if (o_frame_end !== e.fend) begin
                    $error("frame_end: expected %0d, got %0d", e.fend, o_frame_end);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL gradient_non_max_suppression_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One register transfer; the model takes the value at the same edge.
    task automatic write_reg(input logic [gnms_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= gnms_pkg::CFG_DATA_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            gnms_pkg::REG_WIDTH:  width_reg = 12'(value);
            gnms_pkg::REG_HEIGHT: height_reg = 13'(value);
            gnms_pkg::REG_LOW:    low_reg = 11'(value);
            gnms_pkg::REG_HIGH:   high_reg = 11'(value);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued gradient is taken and every result has arrived.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_gradients.size() > 0 || in_valid || expected_edges.size() > 0);
    endtask

    task automatic configure(input int w, input int h, input int lo, input int hi);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(gnms_pkg::REG_WIDTH, w);
        write_reg(gnms_pkg::REG_HEIGHT, h);
        write_reg(gnms_pkg::REG_LOW, lo);
        write_reg(gnms_pkg::REG_HIGH, hi);
        settings_used++;
    endtask

    function automatic t_gradient random_gradient(input int mode);
        t_gradient g;
        case (mode)
            MODE_TIES: begin
                g.gx = gnms_pkg::GRAD_W'(int'($urandom_range(0, 8)) - 4);
                g.gy = gnms_pkg::GRAD_W'(int'($urandom_range(0, 8)) - 4);
            end
            MODE_EDGES: begin
                g.gx = gnms_pkg::GRAD_W'(int'($urandom_range(0, 600)) - 300);
                g.gy = gnms_pkg::GRAD_W'(int'($urandom_range(0, 600)) - 300);
                if ($urandom_range(0, 3) == 0)
                    g.gx = gnms_pkg::GRAD_W'($urandom_range(600, 1020));
                if ($urandom_range(0, 3) == 0)
                    g.gy = -gnms_pkg::GRAD_W'($urandom_range(600, 1020));
            end
            default: begin
                g.gx = gnms_pkg::GRAD_W'($urandom_range(0, 2047));
                g.gy = gnms_pkg::GRAD_W'($urandom_range(0, 2047));
            end
        endcase
        return g;
    endfunction

    task automatic queue_pixels(input int count, input int mode);
        for (int i = 0; i < count; i++)
            pending_gradients.push_back(random_gradient(mode));
    endtask

    // Stimulus plan.
    initial begin
        t_gradient directed [25];
        int w, h, frames, mode;
        directed = '{
            '{0, 0}, '{1023, 0}, '{-1024, -1024}, '{1020, 1020}, '{-1020, 1020},
            '{1020, -1020}, '{0, -1024}, '{-1024, 0}, '{128, 53}, '{53, 128},
            '{-128, 53}, '{53, -128}, '{1, 1}, '{-1, -1}, '{1023, -1024},
            '{0, 1}, '{5, 0}, '{300, 20}, '{20, 300}, '{-300, -300},
            '{100, -100}, '{700, 0}, '{0, 700}, '{-1, 0}, '{0, -1}
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frame: field extremes, every direction and the sector bounds.
        configure(5, 5, 0, 2047);
        foreach (directed[i]) pending_gradients.push_back(directed[i]);

        // Clamped sizes and crossed thresholds.
        configure(2, 0, 2047, 0);
        queue_pixels(9, MODE_EDGES);
        configure(3, 3, 1000, 200);
        queue_pixels(9, MODE_FULL);

        // Tallest height with the frame cut short by a height change.
        configure(3, 8191, 10, 40);
        queue_pixels(30, MODE_EDGES);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(gnms_pkg::REG_HEIGHT, 3);
        queue_pixels(9, MODE_FULL);

        // Width register above the line store depth: the row clamps to 2048 pixels.
        configure(13'h1FFF, 3, 30, 60);
        queue_pixels(120, MODE_FULL);

        // Long receiver hold while the sender keeps offering pixels.
        configure(8, 6, 30, 60);
        burst = 1'b1;
        queue_pixels(96, MODE_EDGES);
        repeat (200) @(posedge i_clk);
        hold_req = 1'b1;
        wait_drained();
        burst = 1'b0;

        // Random frames of small size with random thresholds.
        while (grads_taken < 900) begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 6);
            mode = $urandom_range(0, 2);
            frames = $urandom_range(1, 2);
            configure(w, h, $urandom_range(0, 1200), $urandom_range(0, 1500));
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0) begin
                // Sender pauses mid-frame until every result is in.
                queue_pixels(w * h / 2, mode);
                wait_drained();
                queue_pixels(w * h - w * h / 2 + (frames - 1) * w * h, mode);
            end else begin
                queue_pixels(frames * w * h, mode);
            end
            if ($urandom_range(0, 9) == 0) begin
                @(posedge i_clk);
                hold_req = 1'b1;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d gradient transfers and %0d results (%0d kept) over %0d settings,",
                 grads_taken, edges_seen, kept_seen, settings_used);
        $display("including clamped sizes, a long output hold and a height cut mid-frame.");
        if (errors == 0) begin
            $display("PASS gradient_non_max_suppression_core");
        end else begin
            $display("FAIL gradient_non_max_suppression_core");
        end
        $finish;
    end

endmodule
